// ===== rtl/core/pip_pkg.sv =====
`timescale 1ns / 1ps

package pip_pkg;

  localparam int PIP_MAX_VERTICES = 64;
  localparam int PIP_FRAC_BITS    = 16;
  localparam int COORD_W          = 17;
  localparam int VTX_W            = 2 * COORD_W;
  localparam int TOL_W            = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 32'd429496;
  localparam int RAY_END_X        = 3;
  localparam int MIN_VERTS        = 3;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEST   = 2'd2;

  typedef enum logic [1:0] {
    TURN_COL,
    TURN_CW,
    TURN_CCW
  } turn_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD0,
    ST_LD1,
    ST_LD2,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_T5,
    ST_EV,
    ST_FIN
  } pip_state_t;

  // signed width holding any coordinate and the ray end at 3.0
  function automatic int pt_w(input int frac);
    int w;
    begin
      w = (COORD_W > frac + 2) ? COORD_W : frac + 2;
      return w + 1;
    end
  endfunction

endpackage

// ===== rtl/core/pip_channels.sv =====
`timescale 1ns / 1ps

interface pip_in_if;
  import pip_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;

  modport source (output valid, command, coord_x, coord_y, input ready);
  modport sink   (input valid, command, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic overflowed;

  modport source (output valid, inside_res, overflowed, input ready);
  modport sink   (input valid, inside_res, overflowed, output ready);
endinterface

// ===== rtl/core/pip_turn.sv =====
`timescale 1ns / 1ps

// orientation of (p,q,r); products registered, code valid in the cycle after the operands
module pip_turn import pip_pkg::*; #(
  parameter int FRAC_BITS = PIP_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic [TOL_W-1:0]                      tol,
  input  logic signed [pt_w(FRAC_BITS)-1:0]     px,
  input  logic signed [pt_w(FRAC_BITS)-1:0]     py,
  input  logic signed [pt_w(FRAC_BITS)-1:0]     qx,
  input  logic signed [pt_w(FRAC_BITS)-1:0]     qy,
  input  logic signed [pt_w(FRAC_BITS)-1:0]     rx,
  input  logic signed [pt_w(FRAC_BITS)-1:0]     ry,
  output turn_t                                 code
);

  localparam int PT_W   = pt_w(FRAC_BITS);
  localparam int DIFF_W = PT_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int V_W    = PROD_W + 1;
  localparam int SH     = 2 * FRAC_BITS - TOL_W;
  localparam int TOL_SH = (SH > 0) ? SH : 0;
  localparam int MAG_SH = (SH < 0) ? -SH : 0;
  localparam int CMP_W  = (V_W + MAG_SH > TOL_W + TOL_SH) ? V_W + MAG_SH : TOL_W + TOL_SH;

  logic signed [DIFF_W-1:0] d1, d2, d3, d4;
  logic signed [PROD_W-1:0] m1_r, m2_r;
  logic signed [V_W-1:0]    v;
  logic [V_W-1:0]           mag;
  logic [CMP_W-1:0]         mag_ext, tol_ext;
  logic                     tiny;

  assign d1 = DIFF_W'(qy) - DIFF_W'(py);
  assign d2 = DIFF_W'(rx) - DIFF_W'(qx);
  assign d3 = DIFF_W'(qx) - DIFF_W'(px);
  assign d4 = DIFF_W'(ry) - DIFF_W'(qy);

  always_ff @(posedge clk) begin
    m1_r <= d1 * d2;
    m2_r <= d3 * d4;
  end

  always_comb begin
    v       = V_W'(m1_r) - V_W'(m2_r);
    mag     = v[V_W-1] ? V_W'(-v) : V_W'(v);
    mag_ext = CMP_W'(mag) << MAG_SH;
    tol_ext = CMP_W'(tol) << TOL_SH;
    tiny    = mag_ext < tol_ext;
    if (tiny) begin
      code = TURN_COL;
    end else if (!v[V_W-1] && (|v)) begin
      code = TURN_CW;
    end else begin
      code = TURN_CCW;
    end
  end

endmodule

// ===== rtl/core/point_in_polygon_test.sv =====
`timescale 1ns / 1ps

// Point-in-polygon test by ray casting.
// in_word carries command, coord_x, coord_y (valid/ready, taken when both high).
// Append past capacity drops the vertex and sets the sticky overflow flag,
// cleared by clear. Neither clear nor append gives a result. A test casts a
// ray from the point to x = 3.0 and walks the polygon edges, one edge at a
// time: each edge needs five orientation checks through one shared
// cross-product unit (two multipliers, registered, then a subtract and tolerance
// compare). A test ends early when the point lies collinear with a crossed
// edge; with fewer than three vertices the answer is 1 and no edge is walked.
// in_word.ready is low during a test, so the next word is taken only once the
// result has moved into the output register. out_word holds one result word
// in an output register: clear and append are taken while it waits; a finished
// test waits until the receiver takes it. cfg_we/cfg_wdata write the collinear
// tolerance (32 fraction bits); the user must write it only while idle, and
// the block itself does not enforce this. Reset (rst_n low, synchronous)
// empties the polygon, clears the overflow flag and output valid, and
// restores the tolerance to about 0.0001.
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = PIP_MAX_VERTICES,
  parameter int FRAC_BITS    = PIP_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  pip_in_if.sink           in_word,
  pip_out_if.source        out_word,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  localparam int PT_W  = pt_w(FRAC_BITS);
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic signed [PT_W-1:0] FAR_X = PT_W'(RAY_END_X) << FRAC_BITS;

  // polygon store, {y,x}
  logic [VTX_W-1:0] mem [MAX_VERTICES];
  logic [VTX_W-1:0] mem_rd_r;
  logic             wr_en, rd_en;
  logic [AW-1:0]    rd_addr;

  pip_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [TOL_W-1:0] tol_r;

  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [VTX_W-1:0]   a_r, a_nxt, b_r, b_nxt, first_r, first_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  turn_t              o1_r, o1_nxt, o2_r, o2_nxt, o3_r, o3_nxt, o4_r, o4_nxt;
  logic               hit_r, hit_nxt;
  logic               res_r, res_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_inside_r, out_inside_nxt;
  logic out_ovf_r, out_ovf_nxt;

  // points widened to the signed working width
  logic signed [PT_W-1:0] ax, ay, bx, by, ptx, pty;
  logic signed [PT_W-1:0] opx, opy, oqx, oqy, orx, ory;
  turn_t                  code;
  logic                   more;   // another vertex beyond b
  logic                   last;   // closing edge
  logic                   meet;

  function automatic logic in_box(input logic signed [PT_W-1:0] p_x, p_y, q_x, q_y,
                                  r_x, r_y);
    in_box = (q_x <= p_x || q_x <= r_x) && (q_x >= p_x || q_x >= r_x) &&
             (q_y <= p_y || q_y <= r_y) && (q_y >= p_y || q_y >= r_y);
  endfunction

  assign ax  = PT_W'(a_r[COORD_W-1:0]);
  assign ay  = PT_W'(a_r[VTX_W-1:COORD_W]);
  assign bx  = PT_W'(b_r[COORD_W-1:0]);
  assign by  = PT_W'(b_r[VTX_W-1:COORD_W]);
  assign ptx = PT_W'(px_r);
  assign pty = PT_W'(py_r);

  assign more = ((CNT_W + 1)'(i_r) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(cnt_r);
  assign last = CNT_W'(i_r) == (cnt_r - CNT_W'(1));

  // ray is horizontal from p to (3.0, py)
  assign meet = (o1_r != o2_r && o3_r != o4_r) ||
                (o1_r == TURN_COL && in_box(ax, ay, ptx, pty, bx, by)) ||
                (o2_r == TURN_COL && in_box(ax, ay, FAR_X, pty, bx, by)) ||
                (o3_r == TURN_COL && in_box(ptx, pty, ax, ay, FAR_X, pty)) ||
                (o4_r == TURN_COL && in_box(ptx, pty, bx, by, FAR_X, pty));

  pip_turn #(.FRAC_BITS(FRAC_BITS)) u_turn (
    .clk  (clk),
    .tol  (tol_r),
    .px   (opx),
    .py   (opy),
    .qx   (oqx),
    .qy   (oqy),
    .rx   (orx),
    .ry   (ory),
    .code (code)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= {in_word.coord_y, in_word.coord_x};
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    first_nxt      = first_r;
    i_nxt          = i_r;
    o1_nxt         = o1_r;
    o2_nxt         = o2_r;
    o3_nxt         = o3_r;
    o4_nxt         = o4_r;
    hit_nxt        = hit_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r & ~out_word.ready;
    out_inside_nxt = out_inside_r;
    out_ovf_nxt    = out_ovf_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    // default operands: turn(a, b, p)
    opx = ax;  opy = ay;
    oqx = bx;  oqy = by;
    orx = ptx; ory = pty;

    case (state_r)
      ST_IDLE: begin
        if (in_word.valid) begin
          case (in_word.command)
            CMD_CLEAR: begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
            CMD_APPEND: begin
              if (cnt_r < CNT_W'(MAX_VERTICES)) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_TEST: begin
              px_nxt = in_word.coord_x;
              py_nxt = in_word.coord_y;
              if (cnt_r < CNT_W'(MIN_VERTS)) begin
                res_nxt   = 1'b1;
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_LD0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LD0: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ST_LD1;
      end
      ST_LD1: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(1);
        first_nxt = mem_rd_r;
        a_nxt     = mem_rd_r;
        i_nxt     = '0;
        hit_nxt   = 1'b0;
        state_nxt = ST_LD2;
      end
      ST_LD2: begin
        b_nxt     = mem_rd_r;
        state_nxt = ST_T1;
      end
      ST_T1: begin
        // fetch the vertex after b while this edge runs
        rd_en     = more;
        rd_addr   = i_r + AW'(2);
        state_nxt = ST_T2;
      end
      ST_T2: begin
        orx = FAR_X;
        o1_nxt    = code;
        state_nxt = ST_T3;
      end
      ST_T3: begin
        opx = ptx;   opy = pty;
        oqx = FAR_X; oqy = pty;
        orx = ax;    ory = ay;
        o2_nxt    = code;
        state_nxt = ST_T4;
      end
      ST_T4: begin
        opx = ptx;   opy = pty;
        oqx = FAR_X; oqy = pty;
        orx = bx;    ory = by;
        o3_nxt    = code;
        state_nxt = ST_T5;
      end
      ST_T5: begin
        // turn(a, p, b): is p on the edge line
        oqx = ptx; oqy = pty;
        orx = bx;  ory = by;
        o4_nxt    = code;
        state_nxt = ST_EV;
      end
      ST_EV: begin
        if (meet && code == TURN_COL) begin
          res_nxt   = in_box(ax, ay, ptx, pty, bx, by);
          state_nxt = ST_FIN;
        end else begin
          hit_nxt = hit_r ^ meet;
          if (last) begin
            res_nxt   = hit_r ^ meet;
            state_nxt = ST_FIN;
          end else begin
            a_nxt     = b_r;
            b_nxt     = more ? mem_rd_r : first_r;
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_T1;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_word.ready) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = res_r;
          out_ovf_nxt    = ovf_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    first_r      <= first_nxt;
    i_r          <= i_nxt;
    o1_r         <= o1_nxt;
    o2_r         <= o2_nxt;
    o3_r         <= o3_nxt;
    o4_r         <= o4_nxt;
    hit_r        <= hit_nxt;
    res_r        <= res_nxt;
    out_inside_r <= out_inside_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign in_word.ready       = (state_r == ST_IDLE);
  assign out_word.valid      = out_valid_r;
  assign out_word.inside_res = out_inside_r;
  assign out_word.overflowed = out_ovf_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pip_pkg::*;

  // --------------------------------------------------------------------------
  // Local constants
  // --------------------------------------------------------------------------
  localparam logic [1:0] CMD_UNUSED = 2'd3;           // ignored by the block
  localparam int COORD_MAX   = (1 << COORD_W) - 1;    // all 17 bits set
  localparam int COORD_ONE   = 1 << PIP_FRAC_BITS;    // 1.0 in fixed point
  localparam int HOLD_CYCLES = 600;                   // long receiver hold-off
  localparam int SETTLE_CYCLES = 10;                  // idle gap before a tolerance write
  localparam int TAIL_CYCLES = 400;                   // idle tail after the final drain
  localparam int LIMIT_NS    = 20_000_000;            // hang-guard limit in ns, well over a run

  typedef struct packed {
    logic inside_res;
    logic overflowed;
  } verdict_t;

  typedef struct {
    longint x;
    longint y;
  } fxpt_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the polygon store, predicts each test verdict when the
  // test word is taken, and checks result words against the oldest verdict.
  // --------------------------------------------------------------------------
  class containment_board;
    logic [VTX_W-1:0] vtx_mem [PIP_MAX_VERTICES];
    int unsigned      vtx_count;
    bit               dropped_flag;
    logic [TOL_W-1:0] tol;
    verdict_t         verdicts_due[$];
    int unsigned      mismatches;
    int unsigned      tests, inside_hits, ovf_hits, drops, appends, clears;

    function new();
      vtx_count    = 0;
      dropped_flag = 0;
      tol          = TOL_RESET;
      mismatches   = 0;
      tests        = 0;
      inside_hits  = 0;
      ovf_hits     = 0;
      drops        = 0;
      appends      = 0;
      clears       = 0;
    endfunction

    function void set_tolerance(logic [TOL_W-1:0] v);
      tol = v;
    endfunction

    function fxpt_t vertex_at(int unsigned i);
      fxpt_t v;
      v.x = longint'(vtx_mem[i % PIP_MAX_VERTICES][COORD_W-1:0]);
      v.y = longint'(vtx_mem[i % PIP_MAX_VERTICES][VTX_W-1:COORD_W]);
      return v;
    endfunction

    // exact cross product, 2*FRAC fraction bits, against a 32-fraction-bit
    // tolerance; an exact zero with zero tolerance falls through to CCW code
    function turn_t orient(fxpt_t p, fxpt_t q, fxpt_t r);
      longint          cp;
      longint unsigned mag;
      longint unsigned lim;
      int              sh;
      bit              tiny;
      cp  = (q.y - p.y) * (r.x - q.x) - (q.x - p.x) * (r.y - q.y);
      mag = (cp < 0) ? -cp : cp;
      lim = 64'(tol);
      sh  = 2 * PIP_FRAC_BITS - TOL_W;
      if (sh >= 0) begin
        tiny = mag < (lim << sh);
      end else begin
        tiny = (mag << (-sh)) < lim;
      end
      if (tiny) return TURN_COL;
      return (cp > 0) ? TURN_CW : TURN_CCW;
    endfunction

    function bit in_box(fxpt_t p, fxpt_t q, fxpt_t r);
      longint hx, lx, hy, ly;
      hx = (p.x > r.x) ? p.x : r.x;
      lx = (p.x < r.x) ? p.x : r.x;
      hy = (p.y > r.y) ? p.y : r.y;
      ly = (p.y < r.y) ? p.y : r.y;
      return q.x <= hx && q.x >= lx && q.y <= hy && q.y >= ly;
    endfunction

    function bit edges_cross(fxpt_t a1, fxpt_t b1, fxpt_t a2, fxpt_t b2);
      turn_t o1, o2, o3, o4;
      o1 = orient(a1, b1, a2);
      o2 = orient(a1, b1, b2);
      o3 = orient(a2, b2, a1);
      o4 = orient(a2, b2, b1);
      if (o1 != o2 && o3 != o4) return 1'b1;
      if (o1 == TURN_COL && in_box(a1, a2, b1)) return 1'b1;
      if (o2 == TURN_COL && in_box(a1, b2, b1)) return 1'b1;
      if (o3 == TURN_COL && in_box(a2, a1, b2)) return 1'b1;
      if (o4 == TURN_COL && in_box(a2, b1, b2)) return 1'b1;
      return 1'b0;
    endfunction

    // odd crossings of the ray out to x = 3.0 mean inside
    function bit point_enclosed(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      fxpt_t       p, far_pt, a, b;
      int unsigned hits;
      hits = 0;
      if (vtx_count < MIN_VERTS) return 1'b1;
      p.x      = longint'(px);
      p.y      = longint'(py);
      far_pt.x = longint'(RAY_END_X) << PIP_FRAC_BITS;
      far_pt.y = p.y;
      for (int unsigned i = 0; i < vtx_count; i++) begin
        a = vertex_at(i);
        b = vertex_at((i + 1 < vtx_count) ? i + 1 : 0);
        if (edges_cross(a, b, p, far_pt)) begin
          if (orient(a, p, b) == TURN_COL) return in_box(a, p, b);
          hits++;
        end
      end
      return hits[0];
    endfunction

    function void note_word(logic [1:0] cmd, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y);
      verdict_t v;
      case (cmd)
        CMD_CLEAR: begin
          vtx_count    = 0;
          dropped_flag = 0;
          clears++;
        end
        CMD_APPEND: begin
          if (vtx_count < PIP_MAX_VERTICES) begin
            vtx_mem[vtx_count] = {y, x};
            vtx_count++;
            appends++;
          end else begin
            dropped_flag = 1;
            drops++;
          end
        end
        CMD_TEST: begin
          v.inside_res = point_enclosed(x, y);
          v.overflowed = dropped_flag;
          verdicts_due = {verdicts_due, v};
          tests++;
          if (v.inside_res) inside_hits++;
          if (v.overflowed) ovf_hits++;
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_word(logic inside_res, logic overflowed);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        flag("result word with no test pending", -1, int'({inside_res, overflowed}));
        return;
      end
      want = verdicts_due.pop_front();
      if (inside_res !== want.inside_res)
        flag("inside_res", int'(want.inside_res), int'(inside_res));
      if (overflowed !== want.overflowed)
        flag("overflowed", int'(want.overflowed), int'(overflowed));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block under test
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [TOL_W-1:0] cfg_wdata;

  always #2 clk = ~clk;

  pip_in_if  in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_test uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  containment_board sb = new;

  // stimulus-side state
  bit          calm;          // no idling on either side while set
  bit          hold_req;      // main asks the receiver for one long hold-off
  bit          hold_done;     // receiver reports the hold-off served
  int unsigned words_sent;    // accepted words, ignored commands excluded
  int unsigned tol_settings;
  logic [COORD_W-1:0] shape_x[$];
  logic [COORD_W-1:0] shape_y[$];

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Result checked before
  // the input is noted; a test never completes in the cycle it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.inside_res, out_ch.overflowed);
      if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.command, in_ch.coord_x, in_ch.coord_y);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure (~28% of cycles), none while calm, and one
  // long hold-off counted here so the block fills and stalls its input.
  // --------------------------------------------------------------------------
  initial begin
    int held;
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 28);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Inputs change on the falling edge; valid stays up between
  // back-to-back words and is dropped only by an idle gap or a drain.
  // --------------------------------------------------------------------------
  task automatic send_word(logic [1:0] cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int gap;
    if (!calm && $urandom_range(99) < 28) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.command = cmd;
    in_ch.coord_x = x;
    in_ch.coord_y = y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  // sender stops and waits for every pending verdict to be answered
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
  endtask

  // register is only written with the block idle
  task automatic write_tolerance(logic [TOL_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_tolerance(v);
    tol_settings++;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(99) < 85) return COORD_W'($urandom_range(0, COORD_ONE));
    return COORD_W'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    return COORD_W'(v);
  endfunction

  // test points aimed at the polygon just built: vertices, edge midpoints,
  // rays through a vertex, near misses, plus plain and full-range noise
  task automatic aim_point(output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
    int n, r, i, j;
    n = shape_x.size();
    r = $urandom_range(99);
    if (n == 0 || r < 35) begin
      px = COORD_W'($urandom_range(0, COORD_ONE));
      py = COORD_W'($urandom_range(0, COORD_ONE));
    end else begin
      i = $urandom_range(n - 1);
      j = (i + 1) % n;
      if (r < 50) begin
        px = shape_x[i];
        py = shape_y[i];
      end else if (r < 70) begin
        px = COORD_W'((int'(shape_x[i]) + int'(shape_x[j])) / 2);
        py = COORD_W'((int'(shape_y[i]) + int'(shape_y[j])) / 2);
      end else if (r < 80) begin
        px = rand_coord();
        py = shape_y[i];
      end else if (r < 90) begin
        px = COORD_W'($urandom_range(0, COORD_MAX));
        py = COORD_W'($urandom_range(0, COORD_MAX));
      end else begin
        px = clamp_coord(int'(shape_x[i]) + int'($urandom_range(0, 8)) - 4);
        py = clamp_coord(int'(shape_y[i]) + int'($urandom_range(0, 8)) - 4);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Random part: mostly clear / build polygon / test a few points, the rest
  // loose words with any command and full-range coordinates.
  // --------------------------------------------------------------------------
  task automatic random_shapes(int unsigned target);
    int k, t, r;
    int x0, x1, y0, y1;
    logic [COORD_W-1:0] px, py;
    while (words_sent < target) begin
      if ($urandom_range(99) < 20) begin
        send_word(2'($urandom_range(3)), COORD_W'($urandom_range(0, COORD_MAX)),
                  COORD_W'($urandom_range(0, COORD_MAX)));
      end else begin
        send_word(CMD_CLEAR, COORD_W'($urandom_range(0, COORD_MAX)),
                  COORD_W'($urandom_range(0, COORD_MAX)));
        shape_x.delete();
        shape_y.delete();
        r = $urandom_range(99);
        if (r < 25) begin
          // axis-aligned box: exact zero cross products on its edges
          x0 = $urandom_range(0, COORD_ONE - 1);
          x1 = $urandom_range(x0 + 1, COORD_ONE);
          y0 = $urandom_range(0, COORD_ONE - 1);
          y1 = $urandom_range(y0 + 1, COORD_ONE);
          shape_x = '{COORD_W'(x0), COORD_W'(x1), COORD_W'(x1), COORD_W'(x0)};
          shape_y = '{COORD_W'(y0), COORD_W'(y0), COORD_W'(y1), COORD_W'(y1)};
        end else begin
          r = $urandom_range(99);
          if (r < 10)      k = $urandom_range(0, 2);
          else if (r < 75) k = $urandom_range(3, 8);
          else if (r < 93) k = $urandom_range(9, 40);
          else             k = $urandom_range(60, 70);   // up to and past capacity
          repeat (k) begin
            shape_x = {shape_x, rand_coord()};
            shape_y = {shape_y, rand_coord()};
          end
        end
        foreach (shape_x[i]) send_word(CMD_APPEND, shape_x[i], shape_y[i]);
        t = $urandom_range(1, 6);
        repeat (t) begin
          aim_point(px, py);
          send_word(CMD_TEST, px, py);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed opening: empty and degenerate polygons, the unit square with
  // inside, boundary, corner and outside points, field extremes and the
  // unused command.
  // --------------------------------------------------------------------------
  task automatic directed_checks();
    send_word(CMD_TEST, 0, 0);                          // no vertices: inside
    send_word(CMD_APPEND, 0, 0);
    send_word(CMD_TEST, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));  // one vertex
    send_word(CMD_APPEND, COORD_W'(COORD_ONE), 0);
    send_word(CMD_APPEND, COORD_W'(COORD_ONE), COORD_W'(COORD_ONE));
    send_word(CMD_APPEND, 0, COORD_W'(COORD_ONE));
    send_word(CMD_TEST, COORD_W'(COORD_ONE / 2), COORD_W'(COORD_ONE / 2));  // centre
    send_word(CMD_TEST, COORD_W'(COORD_ONE), COORD_W'(COORD_ONE / 2));      // right edge
    send_word(CMD_TEST, 0, 0);                          // on a corner
    send_word(CMD_TEST, COORD_W'(COORD_ONE / 2), COORD_W'(COORD_ONE));      // top edge
    send_word(CMD_TEST, 100000, COORD_W'(COORD_ONE / 2));  // right of square
    send_word(CMD_TEST, COORD_W'(COORD_ONE / 2), COORD_W'(COORD_MAX));      // far above
    send_word(CMD_TEST, COORD_W'(COORD_MAX), 0);        // ray on the bottom edge's line
    send_word(CMD_UNUSED, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));        // ignored
    send_word(CMD_TEST, 1, 1);
    send_word(CMD_CLEAR, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    send_word(CMD_TEST, COORD_W'(COORD_ONE / 2), COORD_W'(COORD_ONE / 2));  // empty again
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [COORD_W-1:0] px, py;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_CLEAR;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    words_sent    = 0;
    tol_settings  = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_checks();

    // back-pressure: receiver holds off while tests keep coming, then the
    // sender waits for every verdict
    hold_req = 1'b1;
    send_word(CMD_CLEAR, 0, 0);
    shape_x = '{1000, 60000, 30000};
    shape_y = '{2000, 9000, 64000};
    foreach (shape_x[i]) send_word(CMD_APPEND, shape_x[i], shape_y[i]);
    repeat (20) begin
      aim_point(px, py);
      send_word(CMD_TEST, px, py);
    end
    drain_results();

    // a stretch with no idling on either side
    calm = 1'b1;
    random_shapes(200);
    calm = 1'b0;
    random_shapes(420);

    // tolerance sweep: none, maximum, minimum non-zero, random, reset value
    write_tolerance('0);
    random_shapes(580);
    write_tolerance('1);
    random_shapes(740);
    write_tolerance(1);
    random_shapes(900);
    write_tolerance($urandom);
    random_shapes(1050);
    write_tolerance(TOL_RESET);
    random_shapes(1200);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d clears, %0d vertices kept, %0d dropped, %0d point tests",
             words_sent, sb.clears, sb.appends, sb.drops, sb.tests);
    $display("%0d tests inside, %0d with overflow set, %0d tolerance settings, %0d mismatches",
             sb.inside_hits, sb.ovf_hits, tol_settings, sb.mismatches);
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
